/* sv/swcs_pkg.sv */
// Package for the sparse weighted channel sum unit: sizes, codes and shared types.
package swcs_pkg;

    // Default sizes handed to the top level
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int CHANNELS_DEF    = 64;
    localparam int ELEMENTS_DEF    = 64;
    localparam int OUTPUTS_DEF     = 16;

    // Hard limits set by the field widths
    localparam int TABLE_LIMIT = 256;
    localparam int ACC_LIMIT   = 16;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;

    // Request opcodes
    localparam logic [1:0] OP_WR_ENTRY  = 2'd0;
    localparam logic [1:0] OP_WR_SAMPLE = 2'd1;
    localparam logic [1:0] OP_COMPUTE   = 2'd2;

    // Input request
    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         entry_index;
        logic [5:0]         in_channel;
        logic [5:0]         in_element;
        logic [3:0]         out_channel;
        logic signed [15:0] weight;
        logic signed [15:0] sample_value;
    } t_req;

    // Output result
    typedef struct packed {
        logic [3:0]         result_channel;
        logic signed [39:0] sum_value;
        logic               last;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;     // request taken this cycle
        logic       acc_clear;  // zero all accumulators
        logic       rd_en;      // issue one table entry into the pipe
        logic [7:0] rd_addr;
        logic [4:0] out_lim;    // effective output count of this run
        logic       emit;       // present one sum on the result port
        logic [3:0] emit_idx;
        logic       emit_last;
    } t_dp_cmd;

endpackage

/* sv/swcs_datapath.sv */
// Datapath: entry table, sample frame, multiply pipe, accumulators and result register.
module swcs_datapath #(
    parameter int MAX_ENTRIES = swcs_pkg::MAX_ENTRIES_DEF,
    parameter int CHANNELS    = swcs_pkg::CHANNELS_DEF,
    parameter int ELEMENTS    = swcs_pkg::ELEMENTS_DEF,
    parameter int OUTPUTS     = swcs_pkg::OUTPUTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swcs_pkg::t_req    i_req,
    input  swcs_pkg::t_dp_cmd i_cmd,
    output logic              o_pipe_busy,
    output logic              o_strobe,
    output swcs_pkg::t_result o_result
);

    localparam int TBL_DEPTH   = (MAX_ENTRIES < swcs_pkg::TABLE_LIMIT) ?
                                 MAX_ENTRIES : swcs_pkg::TABLE_LIMIT;
    localparam int TBL_AW      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int ACC_N       = (OUTPUTS < swcs_pkg::ACC_LIMIT) ?
                                 OUTPUTS : swcs_pkg::ACC_LIMIT;
    localparam int ACC_AW      = (ACC_N > 1) ? $clog2(ACC_N) : 1;
    localparam int FRAME_DEPTH = CHANNELS * ELEMENTS;
    localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    // Storage
    logic [31:0]        r_tbl   [TBL_DEPTH];
    logic [15:0]        r_frame [FRAME_DEPTH];
    logic signed [39:0] r_acc   [ACC_N];

    // Pipe registers
    logic [31:0]        r_ent;
    logic               r_v1;
    logic signed [15:0] r_smp;
    logic signed [15:0] r_w2;
    logic [3:0]         r_oc2;
    logic               r_ok2;
    logic               r_v2;
    logic signed [31:0] r_prod;
    logic [3:0]         r_oc3;
    logic               r_v3;

    logic               r_strobe;
    swcs_pkg::t_result  r_out;

    // Request side decode
    logic                w_tbl_we;
    logic [TBL_AW-1:0]   w_tbl_waddr;
    logic                w_frm_we;
    logic [FRAME_AW-1:0] w_frm_waddr;

    // Entry fields as read from the table
    logic [5:0]          w_ch;
    logic [5:0]          w_el;
    logic [3:0]          w_oc;
    logic                w_in_rng;
    logic [FRAME_AW-1:0] w_frm_raddr;
    logic signed [31:0]  w_prod;

    always_comb begin
        w_tbl_we    = i_cmd.accept && (i_req.opcode == swcs_pkg::OP_WR_ENTRY) &&
                      (int'(i_req.entry_index) < TBL_DEPTH);
        w_tbl_waddr = i_req.entry_index[TBL_AW-1:0];
        w_frm_we    = i_cmd.accept && (i_req.opcode == swcs_pkg::OP_WR_SAMPLE) &&
                      (int'(i_req.in_channel) < CHANNELS) &&
                      (int'(i_req.in_element) < ELEMENTS);
        w_frm_waddr = FRAME_AW'(int'(i_req.in_channel) * ELEMENTS +
                                int'(i_req.in_element));
    end

    // Table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl[w_tbl_waddr] <= {i_req.weight, i_req.out_channel,
                                   i_req.in_element, i_req.in_channel};
        end
        r_ent <= r_tbl[i_cmd.rd_addr[TBL_AW-1:0]];
    end

    // Stage 1: locate the sample named by the entry
    always_comb begin
        w_ch        = r_ent[5:0];
        w_el        = r_ent[11:6];
        w_oc        = r_ent[15:12];
        w_in_rng    = (int'(w_ch) < CHANNELS) && (int'(w_el) < ELEMENTS);
        w_frm_raddr = w_in_rng ? FRAME_AW'(int'(w_ch) * ELEMENTS + int'(w_el)) : '0;
    end

    // Frame memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_frm_we) begin
            r_frame[w_frm_waddr] <= i_req.sample_value;
        end
        r_smp <= r_frame[w_frm_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_w2   <= r_ent[31:16];
        r_oc2  <= w_oc;
        r_ok2  <= w_in_rng && ({1'b0, w_oc} < i_cmd.out_lim);
        r_oc3  <= r_oc2;
        r_prod <= w_prod;
    end

    // Stage 2: exact 16 x 16 product
    assign w_prod = r_smp * r_w2;

    // Pipe valid bits; entries that add nothing drop out before the adder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_ok2;
        end
    end

    assign o_pipe_busy = r_v1 || r_v2 || r_v3;

    // Stage 3: accumulate, wrapping at 40 bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            for (int i = 0; i < ACC_N; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_v3) begin
            r_acc[r_oc3[ACC_AW-1:0]] <= r_acc[r_oc3[ACC_AW-1:0]] +
                                        {{8{r_prod[31]}}, r_prod};
        end
    end

    // Result register, shown for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.result_channel <= i_cmd.emit_idx;
            r_out.sum_value      <= r_acc[i_cmd.emit_idx[ACC_AW-1:0]];
            r_out.last           <= i_cmd.emit_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

/* sv/swcs_ctrl.sv */
// Controller: configuration registers and the sequencer for a compute run.
module swcs_ctrl #(
    parameter int MAX_ENTRIES = swcs_pkg::MAX_ENTRIES_DEF,
    parameter int OUTPUTS     = swcs_pkg::OUTPUTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_opcode,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swcs_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                           i_pipe_busy,
    output swcs_pkg::t_dp_cmd              o_cmd
);

    localparam int TBL_DEPTH = (MAX_ENTRIES < swcs_pkg::TABLE_LIMIT) ?
                               MAX_ENTRIES : swcs_pkg::TABLE_LIMIT;
    localparam int ACC_N     = (OUTPUTS < swcs_pkg::ACC_LIMIT) ?
                               OUTPUTS : swcs_pkg::ACC_LIMIT;
    localparam int ECNT_W    = $clog2(TBL_DEPTH + 1);
    localparam int OCNT_W    = $clog2(ACC_N + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [8:0]        r_entry_count;
    logic [4:0]        r_output_count;
    logic [ECNT_W-1:0] r_n, n_n;
    logic [OCNT_W-1:0] r_m, n_m;
    logic [ECNT_W-1:0] r_ecnt, n_ecnt;
    logic [OCNT_W-1:0] r_ocnt, n_ocnt;

    logic              w_accept;
    logic              w_compute;
    logic [ECNT_W-1:0] w_n_sat;
    logic [OCNT_W-1:0] w_m_sat;
    logic [ECNT_W-1:0] w_ecnt_inc;
    logic [OCNT_W-1:0] w_ocnt_inc;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count  <= '0;
            r_output_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swcs_pkg::CFG_ENTRY_COUNT:  r_entry_count  <= i_cfg_data[8:0];
                swcs_pkg::CFG_OUTPUT_COUNT: r_output_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Request handshake and saturated run lengths
    always_comb begin
        busy       = (r_state != ST_IDLE);
        w_accept   = start && !busy;
        w_compute  = w_accept && (i_opcode == swcs_pkg::OP_COMPUTE);
        w_n_sat    = (int'(r_entry_count) > TBL_DEPTH) ? ECNT_W'(TBL_DEPTH) :
                     r_entry_count[ECNT_W-1:0];
        w_m_sat    = (int'(r_output_count) > ACC_N) ? OCNT_W'(ACC_N) :
                     r_output_count[OCNT_W-1:0];
        w_ecnt_inc = r_ecnt + 1'b1;
        w_ocnt_inc = r_ocnt + 1'b1;
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_m     = r_m;
        n_ecnt  = r_ecnt;
        n_ocnt  = r_ocnt;

        o_cmd           = '0;
        o_cmd.accept    = w_accept;
        o_cmd.acc_clear = w_compute;
        o_cmd.rd_addr   = 8'(r_ecnt);
        o_cmd.out_lim   = 5'(r_m);
        o_cmd.emit_idx  = 4'(r_ocnt);

        case (r_state)
            ST_IDLE: begin
                if (w_compute) begin
                    n_n     = w_n_sat;
                    n_m     = w_m_sat;
                    n_ecnt  = '0;
                    n_ocnt  = '0;
                    n_state = (w_n_sat == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.rd_en = 1'b1;
                n_ecnt      = w_ecnt_inc;
                if (w_ecnt_inc == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_pipe_busy) begin
                    n_state = (r_m == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = (w_ocnt_inc == r_m);
                n_ocnt          = w_ocnt_inc;
                if (w_ocnt_inc == r_m) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_m     <= '0;
            r_ecnt  <= '0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_m     <= n_m;
            r_ecnt  <= n_ecnt;
            r_ocnt  <= n_ocnt;
        end
    end

    // Sums are read only once every product has landed
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_pipe_busy)
        else $error("sum emitted while products still in flight");

    // Table reads stay inside the run length
    a_rd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_ecnt < r_n))
        else $error("table read beyond entry count");

    // A compute request holds the unit busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_compute |=> busy)
        else $error("compute request did not start a run");

    // The final sum ends the run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == ST_IDLE))
        else $error("run continued past its final sum");

endmodule

/* sv/sparse_weighted_channel_sum_unit.sv */
// Top level of the sparse weighted channel sum unit: controller plus datapath.
//
//  channel   direction  handshake                 payload
//  request   in         start / busy              i_req    (t_req)
//  result    out        o_strobe, one cycle       o_result (t_result)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Table and sample writes leave busy low.
// A compute holds busy for the whole run: the single table read port issues one
// entry a cycle through a four-stage read, read, multiply, accumulate pipe, then one
// accumulator is read per result.
// Synchronous active-low reset clears control state only; no clearing pass.
// Results cannot be held off; each is on the ports for exactly one cycle.
module sparse_weighted_channel_sum_unit #(
    parameter int MAX_ENTRIES = swcs_pkg::MAX_ENTRIES_DEF,
    parameter int CHANNELS    = swcs_pkg::CHANNELS_DEF,
    parameter int ELEMENTS    = swcs_pkg::ELEMENTS_DEF,
    parameter int OUTPUTS     = swcs_pkg::OUTPUTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  swcs_pkg::t_req                 i_req,
    output logic                           o_strobe,
    output swcs_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swcs_pkg::CFG_DW-1:0]    i_cfg_data
);

    swcs_pkg::t_dp_cmd w_cmd;
    logic              w_pipe_busy;

    // Sequencer
    swcs_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .OUTPUTS     (OUTPUTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_req.opcode),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pipe_busy (w_pipe_busy),
        .o_cmd       (w_cmd)
    );

    // Storage and arithmetic
    swcs_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CHANNELS    (CHANNELS),
        .ELEMENTS    (ELEMENTS),
        .OUTPUTS     (OUTPUTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_pipe_busy (w_pipe_busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the sparse weighted channel sum unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int SETTLE_CYCLES      = 300;   // longest compute plus pipe and emit
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int MAX_GAP            = 64;
    localparam int MIX_ITEMS          = 8;

    // One stored table entry in the predictor
    typedef struct packed {
        logic [5:0]         in_channel;
        logic [5:0]         in_element;
        logic [3:0]         out_channel;
        logic signed [15:0] weight;
    } t_table_entry;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    swcs_pkg::t_req     i_req       = '0;
    logic               o_strobe;
    swcs_pkg::t_result  o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [swcs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [swcs_pkg::CFG_DW-1:0]    i_cfg_data  = '0;

    // Predictor state
    t_table_entry       entry_store [swcs_pkg::TABLE_LIMIT];
    logic signed [15:0] frame_store [swcs_pkg::CHANNELS_DEF*swcs_pkg::ELEMENTS_DEF];
    logic               frame_written [swcs_pkg::CHANNELS_DEF*swcs_pkg::ELEMENTS_DEF];
    logic [11:0]        written_pos [$];
    logic [8:0]         cfg_entry_count  = '0;
    logic [4:0]         cfg_output_count = '0;
    swcs_pkg::t_result  pending_sums [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int idle_pct       = 0;

    sparse_weighted_channel_sum_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Update the predictor with one accepted request; queue the sums it yields
    task automatic predict_sums(input swcs_pkg::t_req r);
        logic signed [39:0] acc [swcs_pkg::ACC_LIMIT];
        logic signed [31:0] prod;
        t_table_entry       e;
        swcs_pkg::t_result  res;
        int                 n;
        int                 m;
        case (r.opcode)
            swcs_pkg::OP_WR_ENTRY: begin
                entry_store[r.entry_index] = '{r.in_channel, r.in_element,
                                               r.out_channel, r.weight};
            end
            swcs_pkg::OP_WR_SAMPLE: begin
                frame_store[{r.in_channel, r.in_element}] = r.sample_value;
                if (!frame_written[{r.in_channel, r.in_element}]) begin
                    frame_written[{r.in_channel, r.in_element}] = 1'b1;
                    written_pos.push_back({r.in_channel, r.in_element});
                end
            end
            swcs_pkg::OP_COMPUTE: begin
                n = (cfg_entry_count > swcs_pkg::MAX_ENTRIES_DEF) ?
                    swcs_pkg::MAX_ENTRIES_DEF : cfg_entry_count;
                m = (cfg_output_count > swcs_pkg::OUTPUTS_DEF) ?
                    swcs_pkg::OUTPUTS_DEF : cfg_output_count;
                if (m > swcs_pkg::ACC_LIMIT) m = swcs_pkg::ACC_LIMIT;
                for (int k = 0; k < swcs_pkg::ACC_LIMIT; k++) acc[k] = '0;
                for (int i = 0; i < n; i++) begin
                    e = entry_store[i];
                    if (e.out_channel < m) begin
                        prod = frame_store[{e.in_channel, e.in_element}] * e.weight;
                        acc[e.out_channel] = acc[e.out_channel] + prod;
                    end
                end
                for (int i = 0; i < m; i++) begin
                    res.result_channel = 4'(i);
                    res.sum_value      = acc[i];
                    res.last           = (i == m - 1);
                    pending_sums.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // Request builders; fields the opcode ignores carry random junk
    function automatic swcs_pkg::t_req mk_op(input logic [1:0] op);
        swcs_pkg::t_req r;
        r = $bits(swcs_pkg::t_req)'({$urandom, $urandom});
        r.opcode = op;
        return r;
    endfunction

    function automatic swcs_pkg::t_req mk_entry(input logic [7:0] idx,
                                                input logic [5:0] ch,
                                                input logic [5:0] el,
                                                input logic [3:0] oc,
                                                input logic signed [15:0] w);
        swcs_pkg::t_req r;
        r = mk_op(swcs_pkg::OP_WR_ENTRY);
        r.entry_index = idx;
        r.in_channel  = ch;
        r.in_element  = el;
        r.out_channel = oc;
        r.weight      = w;
        return r;
    endfunction

    function automatic swcs_pkg::t_req mk_sample(input logic [5:0] ch,
                                                 input logic [5:0] el,
                                                 input logic signed [15:0] v);
        swcs_pkg::t_req r;
        r = mk_op(swcs_pkg::OP_WR_SAMPLE);
        r.in_channel   = ch;
        r.in_element   = el;
        r.sample_value = v;
        return r;
    endfunction

    // Mostly uniform, with the extremes turning up often
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Entries only ever point at samples that have been written
    function automatic swcs_pkg::t_req random_entry(input logic [7:0] idx);
        logic [11:0] p;
        p = written_pos[$urandom_range(written_pos.size() - 1)];
        return mk_entry(idx, p[11:6], p[5:0], 4'($urandom), pick_value());
    endfunction

    function automatic swcs_pkg::t_req random_sample();
        logic [11:0] p;
        p = 12'($urandom);
        if ($urandom_range(1) == 1) p = written_pos[$urandom_range(written_pos.size() - 1)];
        return mk_sample(p[11:6], p[5:0], pick_value());
    endfunction

    function automatic swcs_pkg::t_req random_request();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return random_entry(8'($urandom));
        if (pick < 75) return random_sample();
        if (pick < 93) return mk_op(swcs_pkg::OP_COMPUTE);
        return mk_op(OP_UNUSED);
    endfunction

    // Present one request, holding start until the block takes it
    task automatic send_req(input swcs_pkg::t_req r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_sums(r);
    endtask

    // Stop requests, let every expected sum arrive, then let a silent compute finish
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both counts back to back; valid stays high across the pair
    task automatic set_counts(input logic [8:0] entries, input logic [4:0] outputs);
        i_cfg_index <= swcs_pkg::CFG_ENTRY_COUNT;
        i_cfg_data  <= swcs_pkg::CFG_DW'(entries);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_entry_count = entries;
        i_cfg_index <= swcs_pkg::CFG_OUTPUT_COUNT;
        i_cfg_data  <= swcs_pkg::CFG_DW'(outputs);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_output_count = outputs;
        i_cfg_valid <= 1'b0;
    endtask

    // Field extremes, every opcode and the documented corner cases
    task automatic test_directed_extremes();
        idle_pct = 30;
        set_counts(9'd4, 5'd3);
        send_req(mk_sample(6'd0, 6'd0, 16'sh7fff));
        send_req(mk_sample(6'd63, 6'd63, 16'sh8000));
        send_req(mk_sample(6'd0, 6'd63, -16'sd1));
        send_req(mk_sample(6'd63, 6'd0, 16'sd1));
        send_req(mk_entry(8'd0, 6'd0, 6'd0, 4'd0, 16'sh7fff));
        send_req(mk_entry(8'd1, 6'd63, 6'd63, 4'd0, 16'sh8000));
        // output channel beyond the count adds nothing
        send_req(mk_entry(8'd2, 6'd63, 6'd63, 4'd15, 16'sh8000));
        send_req(mk_entry(8'd3, 6'd0, 6'd63, 4'd2, 16'sh4000));
        send_req(mk_entry(8'd255, 6'd63, 6'd0, 4'd1, -16'sd1));
        send_req(mk_op(OP_UNUSED));
        send_req(mk_op(swcs_pkg::OP_COMPUTE));
        send_req(mk_sample(6'd0, 6'd0, 16'sh8000));
        send_req(mk_op(swcs_pkg::OP_COMPUTE));
        // all sixteen outputs, so the far entry now counts
        wait_idle();
        set_counts(9'd3, 5'd16);
        send_req(mk_op(swcs_pkg::OP_COMPUTE));
        // zero output count: nothing comes back
        wait_idle();
        set_counts(9'd4, 5'd0);
        send_req(mk_op(swcs_pkg::OP_COMPUTE));
        // no entries: a single zero sum marked last
        wait_idle();
        set_counts(9'd0, 5'd1);
        send_req(mk_op(swcs_pkg::OP_COMPUTE));
        // rewritten entry, two computes in a row
        wait_idle();
        set_counts(9'd2, 5'd2);
        send_req(mk_entry(8'd1, 6'd63, 6'd0, 4'd1, 16'sh7fff));
        send_req(mk_op(swcs_pkg::OP_COMPUTE));
        send_req(mk_op(swcs_pkg::OP_COMPUTE));
    endtask

    // Fill the whole table in order, with samples and short computes mixed in
    task automatic test_table_fill();
        wait_idle();
        set_counts(9'd4, 5'd16);
        for (int i = 0; i < swcs_pkg::TABLE_LIMIT; i++) begin
            if (i % 8 == 0) send_req(random_sample());
            send_req(random_entry(8'(i)));
            if (i % 32 == 31) send_req(mk_op(swcs_pkg::OP_COMPUTE));
        end
    endtask

    // Random traffic over a full table under one setting of the counts
    task automatic test_mixed_traffic(input int entries, input int outputs, input int pct);
        wait_idle();
        set_counts(9'(entries), 5'(outputs));
        idle_pct = pct;
        for (int i = 0; i < MIX_ITEMS; i++) send_req(random_request());
    endtask

    // Each strobed sum against the oldest expectation
    always @(posedge i_clk) begin : check_sums
        swcs_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_sums.size() == 0) begin
                flag_mismatch($sformatf("unexpected sum on channel %0d",
                                        o_result.result_channel));
            end else begin
                want = pending_sums.pop_front();
                if (o_result.result_channel !== want.result_channel)
                    flag_mismatch($sformatf("channel %0d, expected %0d",
                                            o_result.result_channel, want.result_channel));
                if (o_result.sum_value !== want.sum_value)
                    flag_mismatch($sformatf("channel %0d sum %0d, expected %0d",
                                            want.result_channel, o_result.sum_value,
                                            want.sum_value));
                if (o_result.last !== want.last)
                    flag_mismatch($sformatf("channel %0d last %b, expected %b",
                                            want.result_channel, o_result.last, want.last));
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < swcs_pkg::CHANNELS_DEF*swcs_pkg::ELEMENTS_DEF; i++)
            frame_written[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_table_fill();
        test_mixed_traffic(256, 16, 88);
        test_mixed_traffic(1, 1, 88);
        test_mixed_traffic($urandom_range(256), $urandom_range(16, 1), 88);
        test_mixed_traffic(511, 31, 0);
        test_mixed_traffic($urandom_range(255), 0, 0);
        test_mixed_traffic(300, 17, 0);
        test_mixed_traffic($urandom_range(256), $urandom_range(16), 0);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
